@@ rtl/dqkd_pkg.sv @@
// Shared types and codes for the deque with key delete.
package dqkd_pkg;

    localparam int ValueW = 32;
    localparam int CountW = 6;
    localparam int OpW    = 3;
    localparam int StatW  = 2;

    typedef logic signed [ValueW-1:0] t_value;
    typedef logic [CountW-1:0]        t_count;

    // Request operation codes carried on the slave tuser.
    typedef enum logic [OpW-1:0] {
        OP_INSERT     = 3'd0,
        OP_DELETE     = 3'd1,
        OP_TAKE_FRONT = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } t_op;

    // Result status codes carried on the master tuser.
    typedef enum logic [StatW-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOKEY = 2'd3
    } t_status;

    // What a cell loads on the next clock edge.
    typedef enum logic [1:0] {
        CC_HOLD       = 2'd0,
        CC_LOAD_LEFT  = 2'd1,
        CC_LOAD_RIGHT = 2'd2,
        CC_LOAD_WRAP  = 2'd3
    } t_cell_cmd;

endpackage

@@ rtl/dqkd_cell.sv @@
// One storage cell of the deque chain: holds a value, compares it with the key.
module dqkd_cell (
    input  logic               i_clk,
    input  dqkd_pkg::t_cell_cmd i_cmd,
    input  dqkd_pkg::t_value   i_left,
    input  dqkd_pkg::t_value   i_right,
    input  dqkd_pkg::t_value   i_wrap,
    input  dqkd_pkg::t_value   i_key,
    output dqkd_pkg::t_value   o_value,
    output logic               o_match
);
    import dqkd_pkg::*;

    t_value r_value;

    // The neighbor feeding this cell depends on the direction of the move.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CC_HOLD:       r_value <= r_value;
            CC_LOAD_LEFT:  r_value <= i_left;
            CC_LOAD_RIGHT: r_value <= i_right;
            CC_LOAD_WRAP:  r_value <= i_wrap;
            default:       r_value <= r_value;
        endcase
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_key);

endmodule

@@ rtl/deque_with_key_delete.sv @@
// Top level of the deque with key delete: a chain of cells plus its controller.
// Insert, delete, pop front and pop back give a single result, registered and
// appearing the cycle after the request is accepted. A dump of N elements gives N
// results, one per cycle unless the result side stalls, by rotating the chain of
// cells through the front cell; no new request is taken until the last is sent.
// Reset is synchronous, active low: it empties the deque and drops any result.
// Cell contents are not cleared; only positions below the occupancy are read.
module deque_with_key_delete #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] op
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] element, [37:32] count, [39:38] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);
    import dqkd_pkg::*;

    // The occupancy must be able to hold DEPTH itself.
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_occ, n_occ;
    logic [CW-1:0]  r_left, n_left;   // dump results still to send
    logic           r_m_valid, n_m_valid;
    t_status        r_m_status, n_m_status;
    t_value         r_m_element, n_m_element;
    t_count         r_m_count, n_m_count;
    logic           r_m_last, n_m_last;

    t_cell_cmd      w_cmd   [DEPTH];
    t_value         w_val   [DEPTH];
    logic [DEPTH-1:0] w_eq;
    logic [DEPTH-1:0] w_valid;  // position holds an element
    logic [DEPTH-1:0] w_tail;   // position is the back element
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_from_first;
    logic           w_found;
    logic           w_out_free;
    logic           w_accept;
    t_op            w_op;
    t_value         w_key;

    assign w_op  = t_op'(s_axis_tuser);
    assign w_key = t_value'(s_axis_tdata);

    // ------------------------------------------------------------------
    // Chain of cells. Each cell sees both neighbors; the front cell takes the
    // inserted value from the left and the back cell of the array its own
    // value from the right. The wrap input carries the front value so that the
    // back element can take it during a dump rotation.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_left;
        t_value w_right;

        if (g == 0) begin : g_front
            assign w_left = w_key;
        end else begin : g_inner_l
            assign w_left = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign w_right = w_val[g];
        end else begin : g_inner_r
            assign w_right = w_val[g+1];
        end

        dqkd_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_val[0]),
            .i_key   (w_key),
            .o_value (w_val[g]),
            .o_match (w_eq[g])
        );

        assign w_valid[g] = (CW'(g) < r_occ);
        assign w_tail[g]  = (CW'(g + 1) == r_occ);
    end

    // Only held elements may match. ORing the two's complement of the match
    // vector with itself marks the first match and every position behind it;
    // the held ones among them are the cells that must move one step toward the front.
    assign w_match      = w_eq & w_valid;
    assign w_found      = |w_match;
    assign w_from_first = w_match | (~w_match + DEPTH'(1));

    // The result register may be refilled when it is empty or being taken.
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_left      = r_left;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_status  = r_m_status;
        n_m_element = r_m_element;
        n_m_count   = r_m_count;
        n_m_last    = r_m_last;
        for (int i = 0; i < DEPTH; i++) begin
            w_cmd[i] = CC_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_m_status  = ST_OK;
                    n_m_element = '0;
                    n_m_last    = 1'b1;
                    n_m_valid   = 1'b1;
                    case (w_op)
                        OP_INSERT: begin
                            if (r_occ >= CW'(DEPTH)) begin
                                n_m_status = ST_FULL;
                            end else begin
                                // Every cell takes its front neighbor; the
                                // front cell takes the new value.
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_cmd[i] = CC_LOAD_LEFT;
                                end
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (w_found) begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (w_from_first[i] && w_valid[i]) begin
                                        w_cmd[i] = CC_LOAD_RIGHT;
                                    end
                                end
                                n_occ = r_occ - CW'(1);
                            end else begin
                                n_m_status = ST_NOKEY;
                            end
                        end
                        OP_TAKE_FRONT: begin
                            if (r_occ == '0) begin
                                n_m_status = ST_EMPTY;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_cmd[i] = CC_LOAD_RIGHT;
                                end
                                n_occ = r_occ - CW'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (r_occ == '0) begin
                                n_m_status = ST_EMPTY;
                            end else begin
                                n_occ = r_occ - CW'(1);
                            end
                        end
                        OP_DUMP: begin
                            if (r_occ == '0) begin
                                n_m_status = ST_EMPTY;
                            end else begin
                                // Results come from the dump sequence instead.
                                n_m_valid = r_m_valid && !m_axis_tready;
                                n_state   = S_DUMP;
                                n_left    = r_occ;
                            end
                        end
                        default: begin
                            // Unused operation codes leave the deque alone.
                        end
                    endcase
                    n_m_count = t_count'(n_occ);
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    // Send the front element and rotate the held elements by
                    // one, so that after the last result the order is restored.
                    n_m_valid   = 1'b1;
                    n_m_status  = ST_OK;
                    n_m_element = w_val[0];
                    n_m_count   = t_count'(r_occ);
                    n_m_last    = (r_left == CW'(1));
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_tail[i]) begin
                            w_cmd[i] = CC_LOAD_WRAP;
                        end else if (w_valid[i]) begin
                            w_cmd[i] = CC_LOAD_RIGHT;
                        end
                    end
                    n_left = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and result registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_left    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_left    <= n_left;
            r_m_valid <= n_m_valid;
        end
        r_m_status  <= n_m_status;
        r_m_element <= n_m_element;
        r_m_count   <= n_m_count;
        r_m_last    <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_count, r_m_element};
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy exceeds depth");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> (r_left != '0) && (r_left <= r_occ))
        else $error("dump counter out of range");

    a_dump_occ_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |=> $stable(r_occ))
        else $error("occupancy changed during a dump");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_op != OP_DUMP) |=> r_m_valid && r_m_last)
        else $error("single-result request gave no final result");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) && w_out_free && (r_left == CW'(1))
            |=> (r_state == S_IDLE) && r_m_valid && r_m_last)
        else $error("dump did not end with a marked result");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the deque with key delete, driven over its stream ports.
`timescale 1ns / 1ps

module tb;
    import dqkd_pkg::*;

    localparam int Depth      = 32;
    localparam int CycleLimit = 500000;
    localparam int ReportMax  = 10;
    localparam int DrainWait  = 8;

    // Op codes the block does not define; it must answer them with a plain ok.
    localparam logic [OpW-1:0] OpUnusedFirst = 3'd5;
    localparam logic [OpW-1:0] OpUnusedLast  = 3'd7;

    localparam t_value ValMin = 32'sh8000_0000;
    localparam t_value ValMax = 32'sh7fff_ffff;

    typedef struct {
        t_status status;
        t_value  element;
        t_count  count;
        logic    last;
    } t_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] value
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [31:0] element, [37:32] count, [39:38] zero
    logic [1:0]  m_axis_tuser;         // [1:0] status
    logic        m_axis_tlast;

    // Shadow copy of the deque contents, front at index 0.
    t_value shadow_cells [Depth];
    int     shadow_held = 0;
    t_reply expected_replies [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int sink_hold   = 0;

    // Idle percentages for the request and result sides; tests change them.
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;

    deque_with_key_delete #(
        .DEPTH(Depth)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Most idle stretches are short; about one in ten is long.
    function automatic int idle_length();
        if ($urandom_range(9, 0) == 0) begin
            return $urandom_range(24, 8);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(9, 0))
            0: return ValMin;
            1: return ValMax;
            2, 3, 4: return t_value'($signed($urandom_range(6, 0)) - 3);
            default: return t_value'($urandom);
        endcase
    endfunction

    // Mostly a key that is present, so deletes reach into the middle of the list.
    function automatic t_value pick_key();
        if (shadow_held > 0 && $urandom_range(3, 0) != 0) begin
            return shadow_cells[$urandom_range(shadow_held - 1, 0)];
        end
        return pick_value();
    endfunction

    function automatic void remove_cell(input int pos);
        for (int i = pos; i + 1 < shadow_held; i++) begin
            shadow_cells[i] = shadow_cells[i + 1];
        end
        shadow_held--;
    endfunction

    // Applies one request to the shadow deque and queues the replies it causes.
    function automatic void predict_replies(input logic [OpW-1:0] op, input t_value value);
        t_reply r;
        int     pos;
        r.status  = ST_OK;
        r.element = '0;
        r.last    = 1'b1;
        pos       = -1;
        case (op)
            OP_INSERT: begin
                if (shadow_held >= Depth) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_held; i > 0; i--) begin
                        shadow_cells[i] = shadow_cells[i - 1];
                    end
                    shadow_cells[0] = value;
                    shadow_held++;
                end
            end
            OP_DELETE: begin
                for (int i = 0; i < shadow_held && pos < 0; i++) begin
                    if (shadow_cells[i] == value) begin
                        pos = i;
                    end
                end
                if (pos >= 0) begin
                    remove_cell(pos);
                end else begin
                    r.status = ST_NOKEY;
                end
            end
            OP_TAKE_FRONT: begin
                if (shadow_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    remove_cell(0);
                end
            end
            OP_POP_BACK: begin
                if (shadow_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_held--;
                end
            end
            OP_DUMP: begin
                if (shadow_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // One reply per element, front to back, last one marked.
                    for (int i = 0; i < shadow_held; i++) begin
                        r.element = shadow_cells[i];
                        r.count   = t_count'(shadow_held);
                        r.last    = (i == shadow_held - 1);
                        expected_replies.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.count = t_count'(shadow_held);
        expected_replies.push_back(r);
    endfunction

    // Presents one request and holds it until the block takes it. Called at a
    // rising edge; returns at the edge where the request was accepted.
    task automatic send_request(input logic [OpW-1:0] op, input t_value value);
        int gap;
        gap = (int'($urandom_range(99, 0)) < src_gap_pct) ? idle_length() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_replies(op, value);
    endtask

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else if (int'($urandom_range(99, 0)) < sink_stall_pct) begin
            sink_hold = idle_length() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compares every accepted reply with the oldest one predicted.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportMax) begin
                    $display("unexpected reply: status %0d element %0d count %0d last %0b",
                             m_axis_tuser, $signed(m_axis_tdata[31:0]),
                             m_axis_tdata[37:32], m_axis_tlast);
                end
            end else begin
                want = expected_replies[0];
                expected_replies.delete(0);
                if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.element
                        || m_axis_tdata[37:32] !== want.count
                        || m_axis_tdata[39:38] !== 2'b00 || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= ReportMax) begin
                        $display("reply mismatch at cycle %0d", cycle_count);
                        $display("  expected status %0d element %0d count %0d last %0b",
                                 want.status, want.element, want.count, want.last);
                        $display("  actual   status %0d element %0d count %0d last %0b pad %b",
                                 m_axis_tuser, $signed(m_axis_tdata[31:0]),
                                 m_axis_tdata[37:32], m_axis_tlast, m_axis_tdata[39:38]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Every operation but insert on an empty deque, plus the undefined op codes.
    task automatic test_empty_deque();
        send_request(OP_DUMP, pick_value());
        send_request(OP_TAKE_FRONT, pick_value());
        send_request(OP_POP_BACK, pick_value());
        send_request(OP_DELETE, pick_value());
        for (int c = OpUnusedFirst; c <= OpUnusedLast; c++) begin
            send_request(OpW'(c), pick_value());
        end
    endtask

    // Extreme values, duplicate keys, and deletes at the front, back and middle.
    task automatic test_extremes_and_delete();
        send_request(OP_INSERT, ValMax);
        send_request(OP_INSERT, ValMin);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, -1);
        send_request(OP_INSERT, ValMin);
        send_request(OP_DUMP, pick_value());
        send_request(OP_DELETE, ValMin);      // first of two equal keys
        send_request(OP_DELETE, 32'sd12345);  // absent key
        send_request(OP_DELETE, ValMax);      // back element
        send_request(OP_DELETE, '0);          // middle element
        send_request(OP_INSERT, 32'sh5555_5555);
        send_request(OP_INSERT, 32'shAAAA_AAAA);
        send_request(OP_DUMP, pick_value());
        send_request(OP_TAKE_FRONT, pick_value());
        send_request(OP_POP_BACK, pick_value());
        send_request(OP_DUMP, pick_value());
    endtask

    // Fill to capacity with no idling, overflow it, then drain with idling.
    task automatic test_fill_and_drain();
        int roll;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        while (shadow_held < Depth) begin
            send_request(OP_INSERT, pick_value());
        end
        repeat (3) send_request(OP_INSERT, pick_value());
        send_request(OP_DUMP, pick_value());
        src_gap_pct    = 30;
        sink_stall_pct = 30;
        while (shadow_held > 0) begin
            roll = $urandom_range(99, 0);
            if (roll < 40) begin
                send_request(OP_DELETE, pick_key());
            end else if (roll < 65) begin
                send_request(OP_TAKE_FRONT, pick_value());
            end else if (roll < 90) begin
                send_request(OP_POP_BACK, pick_value());
            end else begin
                send_request(OP_DUMP, pick_value());
            end
        end
        send_request(OP_POP_BACK, pick_value());
        send_request(OP_DUMP, pick_value());
    endtask

    // Random mix that keeps the occupancy wandering, with idling that varies
    // from one stretch to the next.
    task automatic test_random_mix();
        int roll;
        for (int n = 0; n < 75; n++) begin
            if (n % 25 == 0) begin
                src_gap_pct    = (n % 50 == 0) ? 0 : 50;
                sink_stall_pct = (n == 25) ? 0 : 20 * (n / 25);
            end
            roll = $urandom_range(99, 0);
            if (roll < 38) begin
                send_request(OP_INSERT, pick_value());
            end else if (roll < 62) begin
                send_request(OP_DELETE, pick_key());
            end else if (roll < 74) begin
                send_request(OP_TAKE_FRONT, pick_value());
            end else if (roll < 86) begin
                send_request(OP_POP_BACK, pick_value());
            end else if (roll < 95) begin
                send_request(OP_DUMP, pick_value());
            end else begin
                send_request(OpW'($urandom_range(OpUnusedLast, OpUnusedFirst)), pick_value());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_deque();
        test_extremes_and_delete();
        test_fill_and_drain();
        test_random_mix();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
